>>> hdl/usp_pkg.sv
package usp_pkg;

   localparam int LEN_W = 12;
   localparam int BYTE_W = 8;

   localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
   localparam logic [BYTE_W-1:0] LEAD_MASK = 8'hC0;

   typedef struct packed {
      logic take_beat;   // store the request beat (byte, if any)
      logic scan_start;  // begin backward search from max_length
      logic cut_load;    // load cut result, advance window head
      logic fin_load;    // load final chunk, empty window
      logic cfg_write;   // take new max_length, empty window
   } dp_cmd_type;

   typedef struct packed {
      logic will_cut;    // accepted beat fills the window
      logic scan_done;
   } dp_status_type;

endpackage

>>> hdl/usp_if.sv
interface usp_req_if;
   logic                     valid;
   logic                     ready;
   logic [usp_pkg::BYTE_W-1:0] data_byte;
   logic                     has_byte;
   logic                     end_of_message;
   modport source (output valid, data_byte, has_byte, end_of_message, input ready);
   modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface usp_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [usp_pkg::LEN_W-1:0] chunk_length;
   logic                      final_chunk;
   modport source (output valid, chunk_length, final_chunk, input ready);
   modport sink (input valid, chunk_length, final_chunk, output ready);
endinterface

interface usp_csr_if;
   logic                      valid;
   logic                      ready;
   logic [usp_pkg::LEN_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

>>> hdl/utf8_message_splitter_core.sv
// Splits a UTF-8 byte stream into chunks of at most max_length bytes and
// returns each chunk length. One byte beat is taken per accept. When the
// window reaches max_length+1 bytes the block searches the window
// backward from position max_length, one RAM read per cycle, stopping
// early at the last newline. An end beat adds one final-chunk beat
// (length may be zero). Writing max_length (clamped to 1..MAX_LEN)
// drops any partial message.
module utf8_message_splitter_core #(
   parameter int MAX_LEN = 2048
) (
   input logic clock,
   input logic reset,
   usp_req_if.sink   req_ch,
   usp_rsp_if.source rsp_ch,
   usp_csr_if.sink   csr_ch
);
   import usp_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   usp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_end   (req_ch.end_of_message),
      .csr_valid (csr_ch.valid),
      .csr_ready (csr_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   usp_dp #(.MAX_LEN(MAX_LEN)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .data_byte    (req_ch.data_byte),
      .has_byte     (req_ch.has_byte),
      .cfg_data     (csr_ch.data),
      .chunk_length (rsp_ch.chunk_length),
      .final_chunk  (rsp_ch.final_chunk)
   );

endmodule

>>> hdl/usp_dp.sv
module usp_dp #(
   parameter int MAX_LEN = 2048
) (
   input  logic                        clock,
   input  logic                        reset,
   input  usp_pkg::dp_cmd_type         cmd,
   output usp_pkg::dp_status_type      status,
   input  logic [usp_pkg::BYTE_W-1:0]  data_byte,
   input  logic                        has_byte,
   input  logic [usp_pkg::LEN_W-1:0]   cfg_data,
   output logic [usp_pkg::LEN_W-1:0]   chunk_length,
   output logic                        final_chunk
);
   import usp_pkg::*;

   localparam int DEPTH = MAX_LEN + 1;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(MAX_LEN + 2);

   logic [BYTE_W-1:0] mem [DEPTH];

   logic [CW-1:0] head_ff, head_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] max_ff, max_in;
   logic [CW-1:0] scan_p_ff, scan_p_in;
   logic          issue_ff, issue_in;
   logic [CW-1:0] rd_pos_ff;
   logic          rd_vld_ff, rd_vld_in;
   logic [BYTE_W-1:0] rd_data_ff;
   logic          nl_ff, nl_in, sp_ff, sp_in, ld_ff, ld_in, hib_ff, hib_in;
   logic [CW-1:0] nl_pos_ff, nl_pos_in, sp_pos_ff, sp_pos_in, ld_pos_ff, ld_pos_in;
   logic          done_ff, done_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic          fin_ff, fin_in;

   logic [CW:0]   wsum, rsum, hsum;
   logic [AW-1:0] waddr, raddr;
   logic [CW-1:0] cut_len, fin_len;
   logic [31:0]   cfg_wide;
   logic          hit_nl, hit_sp, hit_ld;

   always_comb begin
      wsum = {1'b0, head_ff} + {1'b0, fill_ff};
      if (wsum >= (CW+1)'(DEPTH)) wsum = wsum - (CW+1)'(DEPTH);
      waddr = wsum[AW-1:0];
      rsum = {1'b0, head_ff} + {1'b0, scan_p_ff};
      if (rsum >= (CW+1)'(DEPTH)) rsum = rsum - (CW+1)'(DEPTH);
      raddr = rsum[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.take_beat && has_byte) mem[waddr] <= data_byte;
      rd_data_ff <= mem[raddr];
      rd_pos_ff <= scan_p_ff;
   end

   always_comb begin
      hit_nl = rd_vld_ff && (rd_pos_ff < max_ff) && (rd_data_ff == NEWLINE_CHAR);
      hit_sp = rd_vld_ff && (rd_pos_ff < max_ff) && (rd_data_ff == SPACE_CHAR);
      hit_ld = rd_vld_ff && ((rd_data_ff & LEAD_MASK) == LEAD_MASK);
      if (nl_ff) cut_len = nl_pos_ff + CW'(1);
      else if (sp_ff) cut_len = sp_pos_ff + CW'(1);
      else if (hib_ff && ld_ff) cut_len = ld_pos_ff;
      else cut_len = max_ff;
      fin_len = fill_ff + CW'(cmd.take_beat && has_byte);
      cfg_wide = 32'(cfg_data);
   end

   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      max_in = max_ff;
      scan_p_in = scan_p_ff;
      issue_in = issue_ff;
      rd_vld_in = issue_ff;
      nl_in = nl_ff;
      sp_in = sp_ff;
      ld_in = ld_ff;
      hib_in = hib_ff;
      nl_pos_in = nl_pos_ff;
      sp_pos_in = sp_pos_ff;
      ld_pos_in = ld_pos_ff;
      done_in = 1'b0;
      len_in = len_ff;
      fin_in = fin_ff;
      hsum = {1'b0, head_ff} + {1'b0, cut_len};
      if (hsum >= (CW+1)'(DEPTH)) hsum = hsum - (CW+1)'(DEPTH);

      if (issue_ff) begin
         if (scan_p_ff == CW'(1)) issue_in = 1'b0;
         else scan_p_in = scan_p_ff - CW'(1);
      end
      if (rd_vld_ff) begin
         if (rd_pos_ff == max_ff) hib_in = rd_data_ff[BYTE_W-1];
         if (hit_nl) begin
            nl_in = 1'b1;
            nl_pos_in = rd_pos_ff;
         end
         if (hit_sp && !sp_ff) begin
            sp_in = 1'b1;
            sp_pos_in = rd_pos_ff;
         end
         if (hit_ld && !ld_ff) begin
            ld_in = 1'b1;
            ld_pos_in = rd_pos_ff;
         end
         if (hit_nl || rd_pos_ff == CW'(1)) begin
            done_in = 1'b1;
            issue_in = 1'b0;
            rd_vld_in = 1'b0;
         end
      end

      if (cmd.take_beat && has_byte) fill_in = fill_ff + CW'(1);
      if (cmd.scan_start) begin
         scan_p_in = max_ff;
         issue_in = 1'b1;
         rd_vld_in = 1'b0;
         nl_in = 1'b0;
         sp_in = 1'b0;
         ld_in = 1'b0;
         hib_in = 1'b0;
      end
      if (cmd.cut_load) begin
         len_in = LEN_W'(cut_len);
         fin_in = 1'b0;
         fill_in = fill_ff - cut_len;
         head_in = hsum[CW-1:0];
      end
      if (cmd.fin_load) begin
         len_in = LEN_W'(fin_len);
         fin_in = 1'b1;
         head_in = '0;
         fill_in = '0;
      end
      if (cmd.cfg_write) begin
         if (cfg_wide == 32'd0) max_in = CW'(1);
         else if (cfg_wide > 32'(MAX_LEN)) max_in = CW'(MAX_LEN);
         else max_in = CW'(cfg_wide);
         head_in = '0;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
         max_ff <= CW'(1372 > MAX_LEN ? MAX_LEN : 1372);
         issue_ff <= 1'b0;
         rd_vld_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
         max_ff <= max_in;
         issue_ff <= issue_in;
         rd_vld_ff <= rd_vld_in;
         done_ff <= done_in;
      end
      scan_p_ff <= scan_p_in;
      nl_ff <= nl_in;
      sp_ff <= sp_in;
      ld_ff <= ld_in;
      hib_ff <= hib_in;
      nl_pos_ff <= nl_pos_in;
      sp_pos_ff <= sp_pos_in;
      ld_pos_ff <= ld_pos_in;
      len_ff <= len_in;
      fin_ff <= fin_in;
   end

   assign status.will_cut = has_byte && (fill_ff >= max_ff);
   assign status.scan_done = done_ff;
   assign chunk_length = len_ff;
   assign final_chunk = fin_ff;

endmodule

>>> hdl/usp_ctrl.sv
module usp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_end,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output usp_pkg::dp_cmd_type    cmd,
   input  usp_pkg::dp_status_type status
);
   import usp_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_CUT = 2'd2;
   localparam logic [1:0] S_FIN = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       end_ff, end_in;
   logic       req_acc, csr_acc;

   assign csr_ready = (state_ff == S_IDLE);
   assign req_ready = (state_ff == S_IDLE) && !csr_valid;
   assign req_acc = req_valid && req_ready;
   assign csr_acc = csr_valid && csr_ready;
   assign rsp_valid = (state_ff == S_CUT) || (state_ff == S_FIN);

   always_comb begin
      state_in = state_ff;
      end_in = end_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.cfg_write = csr_acc;
            if (req_acc) begin
               cmd.take_beat = 1'b1;
               end_in = req_end;
               if (status.will_cut) begin
                  cmd.scan_start = 1'b1;
                  state_in = S_SCAN;
               end else if (req_end) begin
                  cmd.fin_load = 1'b1;
                  state_in = S_FIN;
               end
            end
         end
         S_SCAN: begin
            if (status.scan_done) begin
               cmd.cut_load = 1'b1;
               state_in = S_CUT;
            end
         end
         S_CUT: begin
            if (rsp_ready) begin
               if (end_ff) begin
                  cmd.fin_load = 1'b1;
                  state_in = S_FIN;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_FIN: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         end_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         end_ff <= end_in;
      end
   end

endmodule

>>> hdl/usp_checker.sv
module usp_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      csr_valid,
   input logic                      csr_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [usp_pkg::LEN_W-1:0] chunk_length,
   input logic                      final_chunk
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(chunk_length) && $stable(final_chunk))
      else $error("rsp beat dropped or changed while stalled");

   a_no_dual_accept: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && req_ready && csr_valid && csr_ready))
      else $error("req and csr accepted together");

   a_busy_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready && !csr_ready)
      else $error("input taken while a result is pending");

   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind utf8_message_splitter_core usp_checker u_usp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .csr_valid    (csr_ch.valid),
   .csr_ready    (csr_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .chunk_length (rsp_ch.chunk_length),
   .final_chunk  (rsp_ch.final_chunk)
);
